@@ src/crfq_pkg.sv @@
// shared types, codes and helpers for the can rx frame qualify fifo
// used by can_rx_frame_qualify_fifo_top, its checker and its testbench; no dependencies
`default_nettype none

package crfq_pkg;

   localparam int RING_DEPTH_DEF = 16;

   // field widths
   localparam int CMD_W     = 2;
   localparam int WORD_W    = 32;
   localparam int IDENT_W   = 29;
   localparam int LEN_W     = 4;
   localparam int BYTES_W   = 64;
   localparam int STATUS_W  = 4;
   localparam int TOTAL_W   = 32;

   localparam int REQ_FIELDS_W = CMD_W + 4 * WORD_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = STATUS_W + IDENT_W + LEN_W + BYTES_W + TOTAL_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   // header bit positions
   localparam int EXT_BIT   = 30;
   localparam int RTR_BIT   = 29;
   localparam int FDF_BIT   = 21;
   localparam int BRS_BIT   = 20;
   localparam int DLC_LO    = 16;

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(8);

   // commands
   localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_STORED   = 4'd0;
   localparam logic [STATUS_W-1:0] ST_STD_ID   = 4'd1;
   localparam logic [STATUS_W-1:0] ST_REMOTE   = 4'd2;
   localparam logic [STATUS_W-1:0] ST_FD       = 4'd3;
   localparam logic [STATUS_W-1:0] ST_BRS      = 4'd4;
   localparam logic [STATUS_W-1:0] ST_BAD_LEN  = 4'd5;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 4'd6;
   localparam logic [STATUS_W-1:0] ST_POPPED   = 4'd7;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 4'd8;
   localparam logic [STATUS_W-1:0] ST_FLUSHED  = 4'd9;

   typedef struct packed {
      logic [BYTES_W-1:0] payload;
      logic [LEN_W-1:0]   length;
      logic [IDENT_W-1:0] ident;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // zero every byte at or beyond len
   function automatic logic [BYTES_W-1:0] keep_bytes(input logic [BYTES_W-1:0] data,
                                                     input logic [LEN_W-1:0] len);
      logic [BYTES_W-1:0] res;
      res = '0;
      for (int i = 0; i < BYTES_W / 8; i++) begin
         if (LEN_W'(i) < len) begin
            res[i*8 +: 8] = data[i*8 +: 8];
         end
      end
      return res;
   endfunction

endpackage

`default_nettype wire

@@ src/can_rx_frame_qualify_fifo_top.sv @@
// can receive frame qualifier and ring fifo, top level
// depends on crfq_pkg and crfq_ram
`default_nettype none

// Each req beat carries a push, pop or flush command and gives exactly one
// rsp beat. Push, flush and unknown commands answer straight from S_IDLE; a
// pop of a non-empty ring goes through S_READ first, since the frame ram has
// registered read data. A new beat is taken in S_IDLE once the result register
// is free or is being emptied in the same cycle, so with rsp_tready held high a
// stream of pushes runs at one beat per clock, while a pop takes no new beat
// until its ram read is done. The ring holds RING_DEPTH-1 frames; error_total
// is the wrapping sum of all reject and overflow counts after the command.
module can_rx_frame_qualify_fifo_top
   import crfq_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // command, header_word0, header_word1, payload_low, payload_high
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // status, frame_ident, frame_length, frame_bytes, error_total
   output logic      [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int SLOT_W = $clog2(RING_DEPTH);

   typedef enum logic {
      S_IDLE,
      S_READ
   } state_type;

   state_type           state_ff, state_in;
   logic [SLOT_W-1:0]   write_slot_ff, write_slot_in;
   logic [SLOT_W-1:0]   read_slot_ff, read_slot_in;
   logic [TOTAL_W-1:0]  reject_total_ff, reject_total_in;
   logic [TOTAL_W-1:0]  overflow_ff, overflow_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                req_accept;
   logic [CMD_W-1:0]    cmd;
   logic [WORD_W-1:0]   hdr0, hdr1;
   logic [BYTES_W-1:0]  data;
   logic [LEN_W-1:0]    dlc;
   logic [STATUS_W-1:0] check_status;
   logic [SLOT_W-1:0]   next_slot;
   logic                ring_full, ring_empty;

   logic                wr_en, rd_en;
   entry_type           wr_entry, rd_entry;
   logic [SLOT_W-1:0]   rd_addr;
   logic [LEN_W-1:0]    pop_len;

   logic [STATUS_W-1:0] o_status;
   logic [IDENT_W-1:0]  o_ident;
   logic [LEN_W-1:0]    o_len;
   logic [BYTES_W-1:0]  o_bytes;
   logic [TOTAL_W-1:0]  o_total;

   assign cmd  = req_tdata[CMD_W-1:0];
   assign hdr0 = req_tdata[CMD_W +: WORD_W];
   assign hdr1 = req_tdata[CMD_W + WORD_W +: WORD_W];
   assign data = req_tdata[CMD_W + 2*WORD_W +: BYTES_W];
   assign dlc  = hdr1[DLC_LO +: LEN_W];

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;

   assign next_slot  = write_slot_ff + SLOT_W'(1);
   assign rd_addr    = read_slot_ff + SLOT_W'(1);
   assign ring_full  = (next_slot == read_slot_ff);
   assign ring_empty = (write_slot_ff == read_slot_ff);

   // first failing check wins
   always_comb begin
      if (!hdr0[EXT_BIT]) begin
         check_status = ST_STD_ID;
      end else if (hdr0[RTR_BIT]) begin
         check_status = ST_REMOTE;
      end else if (hdr1[FDF_BIT]) begin
         check_status = ST_FD;
      end else if (hdr1[BRS_BIT]) begin
         check_status = ST_BRS;
      end else if (dlc > MAX_LEN) begin
         check_status = ST_BAD_LEN;
      end else begin
         check_status = ST_STORED;
      end
   end

   assign wr_entry.ident   = hdr0[IDENT_W-1:0];
   assign wr_entry.length  = dlc;
   assign wr_entry.payload = data;

   // a pop reads the slot after read_slot; a push into that slot is written to
   // the ram before the pop can read it, so no forwarding is needed
   crfq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (RING_DEPTH)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (next_slot),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   assign pop_len = (rd_entry.length > MAX_LEN) ? MAX_LEN : rd_entry.length;

   always_comb begin
      state_in        = state_ff;
      write_slot_in   = write_slot_ff;
      read_slot_in    = read_slot_ff;
      reject_total_in = reject_total_ff;
      overflow_in     = overflow_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      wr_en           = 1'b0;
      rd_en           = 1'b0;
      o_status        = ST_EMPTY;
      o_ident         = '0;
      o_len           = '0;
      o_bytes         = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               rsp_valid_in = 1'b1;
               unique case (cmd)
                  CMD_PUSH: begin
                     if (check_status != ST_STORED) begin
                        o_status        = check_status;
                        reject_total_in = reject_total_ff + TOTAL_W'(1);
                     end else if (ring_full) begin
                        o_status    = ST_OVERFLOW;
                        overflow_in = overflow_ff + TOTAL_W'(1);
                     end else begin
                        o_status      = ST_STORED;
                        wr_en         = 1'b1;
                        write_slot_in = next_slot;
                     end
                  end
                  CMD_POP: begin
                     if (!ring_empty) begin
                        rd_en        = 1'b1;
                        read_slot_in = rd_addr;
                        rsp_valid_in = 1'b0;
                        state_in     = S_READ;
                     end
                  end
                  CMD_FLUSH: begin
                     o_status      = ST_FLUSHED;
                     write_slot_in = '0;
                     read_slot_in  = '0;
                     overflow_in   = '0;
                  end
                  default: begin
                     o_status = ST_EMPTY;
                  end
               endcase
            end
         end
         S_READ: begin
            rsp_valid_in = 1'b1;
            o_status     = ST_POPPED;
            o_ident      = rd_entry.ident;
            o_len        = pop_len;
            o_bytes      = keep_bytes(rd_entry.payload, pop_len);
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign o_total = reject_total_in + overflow_in;

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (rsp_valid_in && !(rsp_valid_ff && !rsp_tready)) begin
         rsp_data_in = RSP_TDATA_W'({o_total, o_bytes, o_len, o_ident, o_status});
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff        <= S_IDLE;
         write_slot_ff   <= '0;
         read_slot_ff    <= '0;
         reject_total_ff <= '0;
         overflow_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         write_slot_ff   <= write_slot_in;
         read_slot_ff    <= read_slot_in;
         reject_total_ff <= reject_total_in;
         overflow_ff     <= overflow_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // the result register is free while the ram read is in flight
   a_read_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> !rsp_valid_ff)
      else $error("result register busy during frame read");

   // a pop that reads the ram always produces a beat on the next cycle
   a_read_gives_beat: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |=> rsp_valid_ff)
      else $error("frame read did not produce a result");

   // a stored frame leaves the ring non-empty
   a_push_not_empty: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (write_slot_ff != read_slot_ff))
      else $error("ring empty right after a stored frame");

   // flush leaves an empty ring with no overflow count
   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (cmd == CMD_FLUSH)) |=>
         (write_slot_ff == '0) && (read_slot_ff == '0) && (overflow_ff == '0))
      else $error("flush did not clear the ring");

endmodule

`default_nettype wire

@@ src/crfq_ram.sv @@
// generic single-write, single-read ram with registered read data
// depends on nothing
`default_nettype none

module crfq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ test/can_rx_frame_qualify_fifo_checker.sv @@
// result checker for can_rx_frame_qualify_fifo_top: predicts every rsp beat from the req
// beats it sees and compares field by field; depends on crfq_pkg
`default_nettype none

module can_rx_frame_qualify_fifo_checker
   import crfq_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   input  wire logic                   req_tready,
   // command, header_word0, header_word1, payload_low, payload_high
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   input  wire logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   // status, frame_ident, frame_length, frame_bytes, error_total
   input  wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   output int                          mismatches,
   output int                          awaited
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOT_W      = $clog2(RING_DEPTH_DEF);
   localparam int NUM_REJECTS = 5;
   localparam int REJ_IDX_W   = $clog2(NUM_REJECTS);

   typedef struct packed {
      logic [WORD_W-1:0] payload_high;
      logic [WORD_W-1:0] payload_low;
      logic [WORD_W-1:0] header_word1;
      logic [WORD_W-1:0] header_word0;
      logic [CMD_W-1:0]  command;
   } frame_cmd_type;

   typedef struct packed {
      logic [TOTAL_W-1:0]  error_total;
      logic [BYTES_W-1:0]  frame_bytes;
      logic [LEN_W-1:0]    frame_length;
      logic [IDENT_W-1:0]  frame_ident;
      logic [STATUS_W-1:0] status;
   } frame_result_type;

   // shadow copy of the ring and its counters
   logic [IDENT_W-1:0] ident_mem   [RING_DEPTH_DEF];
   logic [LEN_W-1:0]   length_mem  [RING_DEPTH_DEF];
   logic [BYTES_W-1:0] payload_mem [RING_DEPTH_DEF];
   logic [SLOT_W-1:0]  fill_slot;
   logic [SLOT_W-1:0]  drain_slot;
   logic [TOTAL_W-1:0] reject_count [NUM_REJECTS];
   logic [TOTAL_W-1:0] overflow_count;

   frame_result_type expected_frames [$];
   int rsp_beats;

   task automatic apply_command(input frame_cmd_type cmd, output frame_result_type res);
      logic [LEN_W-1:0]    code;
      logic [LEN_W-1:0]    len;
      logic [SLOT_W-1:0]   next_slot;
      logic [STATUS_W-1:0] verdict;
      logic [TOTAL_W-1:0]  sum;
      res = '0;
      res.status = ST_EMPTY;
      code = cmd.header_word1[DLC_LO +: LEN_W];
      case (cmd.command)
         CMD_PUSH: begin
            // first failing check wins
            if (!cmd.header_word0[EXT_BIT]) verdict = ST_STD_ID;
            else if (cmd.header_word0[RTR_BIT]) verdict = ST_REMOTE;
            else if (cmd.header_word1[FDF_BIT]) verdict = ST_FD;
            else if (cmd.header_word1[BRS_BIT]) verdict = ST_BRS;
            else if (code > MAX_LEN) verdict = ST_BAD_LEN;
            else verdict = ST_STORED;
            next_slot = fill_slot + 1'b1;
            if (verdict != ST_STORED) begin
               reject_count[REJ_IDX_W'(verdict - ST_STD_ID)] += 1;
            end else if (next_slot == drain_slot) begin
               overflow_count += 1;
               verdict = ST_OVERFLOW;
            end else begin
               fill_slot = next_slot;
               ident_mem[next_slot]   = cmd.header_word0[IDENT_W-1:0];
               length_mem[next_slot]  = code;
               payload_mem[next_slot] = {cmd.payload_high, cmd.payload_low};
            end
            res.status = verdict;
         end
         CMD_POP: begin
            if (fill_slot != drain_slot) begin
               drain_slot = drain_slot + 1'b1;
               len = (length_mem[drain_slot] > MAX_LEN) ? MAX_LEN : length_mem[drain_slot];
               res.status       = ST_POPPED;
               res.frame_ident  = ident_mem[drain_slot];
               res.frame_length = len;
               if (len >= MAX_LEN) begin
                  res.frame_bytes = payload_mem[drain_slot];
               end else begin
                  res.frame_bytes = payload_mem[drain_slot] & ((64'd1 << (8 * len)) - 64'd1);
               end
            end
         end
         CMD_FLUSH: begin
            fill_slot      = '0;
            drain_slot     = '0;
            overflow_count = '0;
            res.status     = ST_FLUSHED;
         end
         default: begin
            // unknown command leaves everything alone
         end
      endcase
      sum = overflow_count;
      for (int i = 0; i < NUM_REJECTS; i++) begin
         sum += reject_count[i];
      end
      res.error_total = sum;
   endtask

   task automatic report_mismatch(input string field, input logic [63:0] want,
                                  input logic [63:0] got);
      $display("rsp beat %0d: %s expected %0h got %0h", rsp_beats, field, want, got);
      mismatches++;
   endtask

   always @(posedge clock) begin : watch
      frame_result_type want;
      frame_result_type got;
      if (reset) begin
         fill_slot      <= '0;
         drain_slot     <= '0;
         overflow_count <= '0;
         for (int i = 0; i < NUM_REJECTS; i++) begin
            reject_count[i] <= '0;
         end
         expected_frames.delete();
         rsp_beats  <= 0;
         mismatches <= 0;
         awaited    <= 0;
      end else begin
         // results first, so a beat with nothing awaited is never masked
         if (rsp_tvalid && rsp_tready) begin
            got = frame_result_type'(rsp_tdata[RSP_FIELDS_W-1:0]);
            if (expected_frames.size() == 0) begin
               report_mismatch("beat with nothing awaited, status", '0, 64'(got.status));
            end else begin
               want = expected_frames.pop_front();
               if (got.status !== want.status)
                  report_mismatch("status", 64'(want.status), 64'(got.status));
               if (got.frame_ident !== want.frame_ident)
                  report_mismatch("frame_ident", 64'(want.frame_ident), 64'(got.frame_ident));
               if (got.frame_length !== want.frame_length)
                  report_mismatch("frame_length", 64'(want.frame_length),
                                  64'(got.frame_length));
               if (got.frame_bytes !== want.frame_bytes)
                  report_mismatch("frame_bytes", want.frame_bytes, got.frame_bytes);
               if (got.error_total !== want.error_total)
                  report_mismatch("error_total", 64'(want.error_total), 64'(got.error_total));
            end
            rsp_beats++;
         end
         if (req_tvalid && req_tready) begin
            apply_command(frame_cmd_type'(req_tdata[REQ_FIELDS_W-1:0]), want);
            expected_frames.push_back(want);
         end
         awaited <= expected_frames.size();
      end
   end

endmodule

`default_nettype wire

@@ test/can_rx_frame_qualify_fifo_top_tb.sv @@
// testbench top for can_rx_frame_qualify_fifo_top: drives push, pop, flush and unknown beats with
// random idling on both sides; depends on crfq_pkg, the top and can_rx_frame_qualify_fifo_checker
`default_nettype none

module can_rx_frame_qualify_fifo_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import crfq_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 1450;
   localparam int BLOCK_LEN    = 64;
   localparam int MAX_GAP      = 16;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tready = 1'b0;
   wire logic              req_tready;
   wire logic              rsp_tvalid;
   wire logic [RSP_TDATA_W-1:0] rsp_tdata;

   int          mismatches;
   int          awaited;
   int unsigned cycle_count = 0;
   bit          sender_fast   = 1'b0;
   bit          receiver_fast = 1'b0;
   int unsigned rsp_hold = 0;
   int unsigned rsp_draw;

   can_rx_frame_qualify_fifo_top #(
      .RING_DEPTH(RING_DEPTH_DEF)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   can_rx_frame_qualify_fifo_checker u_frame_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .mismatches (mismatches),
      .awaited    (awaited)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("can_rx_frame_qualify_fifo_top regression: fail");
         $finish;
      end
   end

   // result side: after each accepted beat, stall for a random number of cycles
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= 0;
      end else if (rsp_hold != 0) begin
         rsp_hold <= rsp_hold - 1;
         if (rsp_hold == 1) rsp_tready <= 1'b1;
      end else if (rsp_tvalid && rsp_tready) begin
         rsp_draw = receiver_fast ? 0 : $urandom_range(0, MAX_GAP);
         if (rsp_draw != 0) begin
            rsp_tready <= 1'b0;
            rsp_hold   <= rsp_draw;
         end
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] h0,
                            input logic [WORD_W-1:0] h1, input logic [WORD_W-1:0] lo,
                            input logic [WORD_W-1:0] hi);
      int unsigned gap;
      gap = sender_fast ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_W'({hi, lo, h1, h0, cmd});
      do @(posedge clock); while (!req_tready);
   endtask

   // hold off the sender until every result is back
   task automatic drain_wait();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (awaited != 0);
   endtask

   function automatic logic [WORD_W-1:0] good_header0();
      return {1'($urandom_range(0, 1)), 1'b1, 1'b0, 29'($urandom)};
   endfunction

   function automatic logic [WORD_W-1:0] good_header1();
      logic [WORD_W-1:0] w;
      w = $urandom;
      w[FDF_BIT] = 1'b0;
      w[BRS_BIT] = 1'b0;
      w[DLC_LO +: LEN_W] = LEN_W'($urandom_range(0, 8));
      return w;
   endfunction

   task automatic send_push(input bit well_formed);
      logic [WORD_W-1:0] h0;
      logic [WORD_W-1:0] h1;
      h0 = good_header0();
      h1 = good_header1();
      if (!well_formed) begin
         // break one check, or send pure noise
         case ($urandom_range(0, 5))
            0: h0[EXT_BIT] = 1'b0;
            1: h0[RTR_BIT] = 1'b1;
            2: h1[FDF_BIT] = 1'b1;
            3: h1[BRS_BIT] = 1'b1;
            4: h1[DLC_LO +: LEN_W] = LEN_W'($urandom_range(9, 15));
            default: begin
               h0 = $urandom;
               h1 = $urandom;
            end
         endcase
      end
      send_beat(CMD_PUSH, h0, h1, $urandom, $urandom);
   endtask

   initial begin : stimulus
      int unsigned pick;
      int unsigned push_pct;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty pop, unknown command, each reject in priority order,
      // length extremes, pops, flush
      send_beat(CMD_POP, '1, '1, '1, '1);
      send_beat(CMD_UNUSED, '1, '1, '1, '1);
      send_beat(CMD_PUSH, 32'hBFFF_FFFF, 32'hFFFF_FFFF, '1, '1);
      send_beat(CMD_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, '1);
      send_beat(CMD_PUSH, 32'h4000_0000, 32'hFFFF_FFFF, '1, '1);
      send_beat(CMD_PUSH, 32'h4000_0000, 32'hFFDF_FFFF, '1, '1);
      send_beat(CMD_PUSH, 32'h4000_0000, 32'hFFCF_FFFF, '1, '1);
      send_beat(CMD_PUSH, 32'h5FFF_FFFF, 32'hFFC9_0000, '1, '1);
      send_beat(CMD_PUSH, 32'hDFFF_FFFF, 32'hFFC8_FFFF, '1, '1);
      send_beat(CMD_PUSH, 32'h4000_0000, 32'h0000_0000, '1, '1);
      send_beat(CMD_PUSH, 32'h4123_4567, 32'h0003_0000, 32'h0123_4567, 32'h89AB_CDEF);
      send_beat(CMD_PUSH, 32'h5FFF_FFFF, 32'hFFC8_FFFF, '0, '0);
      repeat (4) send_beat(CMD_POP, '0, '0, '0, '0);
      send_beat(CMD_POP, '0, '0, '0, '0);
      send_beat(CMD_PUSH, 32'h4000_0055, 32'h0005_0000, '1, '1);
      send_beat(CMD_FLUSH, '0, '0, '0, '0);
      send_beat(CMD_POP, '0, '0, '0, '0);
      send_beat(CMD_PUSH, 32'h4ABC_DEF0, 32'h0001_0000, '1, '1);
      send_beat(CMD_POP, '1, '1, '1, '1);

      // random: blocks that fill, drain or mix, some with no idling at all
      push_pct = 45;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % BLOCK_LEN == 0) begin
            case ($urandom_range(0, 2))
               0: push_pct = 80;
               1: push_pct = 15;
               default: push_pct = 45;
            endcase
            sender_fast = ($urandom_range(0, 3) == 0);
            receiver_fast <= ($urandom_range(0, 3) == 0);
         end
         if (n == RANDOM_ITEMS / 2) drain_wait();
         pick = $urandom_range(0, 99);
         if (pick < push_pct) begin
            send_push($urandom_range(0, 99) < 85);
         end else if (pick < 97) begin
            send_beat(CMD_POP, $urandom, $urandom, $urandom, $urandom);
         end else if (pick < 98) begin
            send_beat(CMD_FLUSH, $urandom, $urandom, $urandom, $urandom);
         end else begin
            send_beat(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom);
         end
      end

      drain_wait();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("can_rx_frame_qualify_fifo_top regression: pass");
      end else begin
         $display("can_rx_frame_qualify_fifo_top regression: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ can_rx_frame_qualify_fifo_top.f @@
src/crfq_pkg.sv
src/crfq_ram.sv
src/can_rx_frame_qualify_fifo_top.sv
test/can_rx_frame_qualify_fifo_checker.sv
test/can_rx_frame_qualify_fifo_top_tb.sv
